### rtl/itvc_pkg.sv
// shared types and constants for the ipv4 text validate and classify block
package itvc_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    localparam logic [7:0]  OCT_TEN       = 8'd10;
    localparam logic [7:0]  OCT_172       = 8'd172;
    localparam logic [7:0]  OCT_192       = 8'd192;
    localparam logic [7:0]  OCT_168       = 8'd168;
    localparam logic [7:0]  OCT_16        = 8'd16;
    localparam logic [7:0]  OCT_31        = 8'd31;
    localparam logic [11:0] MAX_OCTET     = 12'd255;
    localparam logic [1:0]  MAX_DIGITS    = 2'd3;
    localparam logic [1:0]  TEN_DIGITS    = 2'd2;
    localparam logic [1:0]  LAST_OCTET    = 2'd3;

    localparam int OUT_TDATA_W = 40;
    localparam int IN_TDATA_W  = 8;

    typedef struct packed {
        logic [1:0]  octet_index;
        logic [1:0]  digit_count;
        logic [7:0]  octet_value;
        logic [23:0] upper_octets;
        logic        first_is_ten_text;
        logic        open_seen;
        logic        close_seen;
        logic        failed;
    } itvc_state_t;

    typedef struct packed {
        logic [31:0] address;
        logic        priv_flag;
        logic        valid_res;
    } itvc_result_t;

endpackage

### rtl/ipv4_text_validate_classify.sv
// top level: ipv4 dotted-decimal text validator and private-range classifier
//
// Takes the address text one character per transaction on the slave stream,
// tlast on the final character, and returns one result transaction per text on
// the master stream. A character sits in an input register, then the grammar
// state update and the result logic run in a single combinational step into
// the result register, so one character is taken every clock cycle unless a
// final character stalls in the input register, and the result register
// loads when its final character leaves the input register. The input register
// keeps taking characters while a result waits in the output register; only a
// final character stalls there, until the waiting result is taken. The user
// writes bracket_mode over the cfg port while the block is idle; the block does not enforce it.
module ipv4_text_validate_classify (
    input  logic                              clk,
    input  logic                              rst_n,
    // cfg write channel, data bit 0: bracket_mode
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    // character stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [itvc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] ch
    input  logic                              s_axis_tlast,  // last
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [itvc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [0] valid_res, [1] priv_flag,
                                                             // [33:2] address, [39:34] zero
);
    import itvc_pkg::*;

    // bracket mode register
    logic mode_reg;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_ch_reg;
    logic       in_last_reg;

    // result register
    logic         out_valid_reg;
    logic         out_valid_next;
    itvc_result_t out_res_reg;

    logic         advance;
    logic         in_take;
    itvc_result_t result;
    itvc_state_t  pstate;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    // a non-final character never needs the result register
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_ch_reg   <= s_axis_tdata[7:0];
            in_last_reg <= s_axis_tlast;
        end
    end

    itvc_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .ch     (in_ch_reg),
        .last   (in_last_reg),
        .mode   (mode_reg),
        .result (result),
        .state  (pstate)
    );

    // result register loads on the final character of a text
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_res_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_res_reg.address, out_res_reg.priv_flag,
                            out_res_reg.valid_res};

    // private only ever reported for a valid text
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_res_reg.valid_res || !out_res_reg.priv_flag))
        else $error("private flag set on invalid text");

    // invalid text carries a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.valid_res) |-> (out_res_reg.address == 32'd0))
        else $error("nonzero address on invalid text");

    // the final character clears the per-text state
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (pstate == '0))
        else $error("text state not cleared after final character");

    // a final character only moves on when the result register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> out_valid_reg)
        else $error("result lost after final character");

endmodule

### rtl/itvc_parse.sv
// per-character grammar state update and end-of-text result logic
module itvc_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           ch,
    input  logic                 last,
    input  logic                 mode,
    output itvc_pkg::itvc_result_t result,
    output itvc_pkg::itvc_state_t  state
);
    import itvc_pkg::*;

    itvc_state_t st_reg;
    itvc_state_t st_next;
    itvc_state_t upd;
    logic [11:0] digit_val;
    logic [7:0]  o0;
    logic [7:0]  o1;
    logic        ok;

    // value * 10 + digit
    assign digit_val = {1'b0, st_reg.octet_value, 3'b000} + {3'b000, st_reg.octet_value, 1'b0}
                       + {4'd0, ch - CH_ZERO};

    always_comb
    begin
        upd = st_reg;
        if (st_reg.failed)
        begin
            upd = st_reg;
        end
        else if (mode && !st_reg.open_seen)
        begin
            if (ch == CH_OPEN)
                upd.open_seen = 1'b1;
            else
                upd.failed = 1'b1;
        end
        else if (st_reg.close_seen)
        begin
            upd.failed = 1'b1;
        end
        else if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            if (st_reg.digit_count >= MAX_DIGITS || digit_val > MAX_OCTET)
                upd.failed = 1'b1;
            else
            begin
                upd.octet_value = digit_val[7:0];
                upd.digit_count = st_reg.digit_count + 2'd1;
            end
        end
        else if (ch == CH_DOT)
        begin
            if (st_reg.digit_count == 2'd0 || st_reg.octet_index >= LAST_OCTET)
                upd.failed = 1'b1;
            else
            begin
                if (st_reg.octet_index == 2'd0)
                    upd.first_is_ten_text = (st_reg.octet_value == OCT_TEN)
                                            && (st_reg.digit_count == TEN_DIGITS);
                upd.upper_octets = {st_reg.upper_octets[15:0], st_reg.octet_value};
                upd.octet_index  = st_reg.octet_index + 2'd1;
                upd.digit_count  = 2'd0;
                upd.octet_value  = 8'd0;
            end
        end
        else if (ch == CH_CLOSE && mode)
        begin
            if (st_reg.octet_index == LAST_OCTET && st_reg.digit_count != 2'd0)
                upd.close_seen = 1'b1;
            else
                upd.failed = 1'b1;
        end
        else
        begin
            upd.failed = 1'b1;
        end
    end

    // result from the state after this character
    assign o0 = upd.upper_octets[23:16];
    assign o1 = upd.upper_octets[15:8];
    assign ok = !upd.failed && upd.octet_index == LAST_OCTET && upd.digit_count != 2'd0
                && upd.open_seen == mode && upd.close_seen == mode;

    always_comb
    begin
        result.valid_res = ok;
        result.address   = ok ? {upd.upper_octets, upd.octet_value} : 32'd0;
        result.priv_flag = 1'b0;
        if (ok)
        begin
            if (upd.first_is_ten_text)
                result.priv_flag = 1'b1;
            else if (o0 == OCT_172)
                result.priv_flag = (o1 >= OCT_16) && (o1 <= OCT_31);
            else if (o0 == OCT_192 && o1 == OCT_168)
                result.priv_flag = 1'b1;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        if (step)
            st_next = last ? '0 : upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else
            st_reg <= st_next;
    end

    assign state = st_reg;

endmodule
